[hdl/priority_queue_sorted_store_unit_macros.svh]
// ----------------------------------------------------------------------------
// Priority queue sorted store - assertion macros
// Concurrent assertion helpers for the back end.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_SORTED_STORE_UNIT_MACROS_SVH
`define PRIORITY_QUEUE_SORTED_STORE_UNIT_MACROS_SVH

// Same-cycle implication.
`define PQSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqss assertion failed");

// Next-cycle implication.
`define PQSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqss assertion failed");

`endif

[hdl/pqss_pkg.sv]
// ----------------------------------------------------------------------------
// Priority queue sorted store - package
// Shared types and codes for the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package pqss_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;
  localparam int QDEPTH = 2;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_REMOVE  = 2'd1;
  localparam logic [1:0] ACT_DEQUEUE = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     ent;
  } cmd_t;

endpackage

[hdl/pqss_ram.sv]
// ----------------------------------------------------------------------------
// Priority queue sorted store - generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pqss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/pqss_front.sv]
// ----------------------------------------------------------------------------
// Priority queue sorted store - front end
// Accepts input transfers, decodes the action and queues commands.
// ----------------------------------------------------------------------------
module pqss_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic signed [31:0]  in_item_value,
  input  logic signed [31:0]  in_item_priority,
  output logic                cmd_valid,
  output pqss_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);
  import pqss_pkg::*;

  cmd_t       q_r [QDEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       dec;

  always_comb begin
    unique case (in_action)
      ACT_INSERT:  dec.op = ACT_INSERT;
      ACT_REMOVE:  dec.op = ACT_REMOVE;
      ACT_DEQUEUE: dec.op = ACT_DEQUEUE;
      default:     dec.op = ACT_NONE;
    endcase
    dec.ent.value = in_item_value;
    dec.ent.prio  = in_item_priority;
  end

  assign in_stall  = (cnt_r == 2'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

[hdl/pqss_back.sv]
// ----------------------------------------------------------------------------
// Priority queue sorted store - back end
// Executes commands on the entry RAM, runs the heap sort, holds the result.
// ----------------------------------------------------------------------------
`include "priority_queue_sorted_store_unit_macros.svh"

module pqss_back #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  pqss_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_value,
  output logic signed [31:0]  out_priority,
  output logic [6:0]          out_occupancy
);
  import pqss_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int EW = 2 * DATA_W;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SCAN_RD  = 5'd1;
  localparam logic [4:0] S_SCAN_CHK = 5'd2;
  localparam logic [4:0] S_MOVE_RD  = 5'd3;
  localparam logic [4:0] S_MOVE_WR  = 5'd4;
  localparam logic [4:0] S_SORT     = 5'd5;
  localparam logic [4:0] S_P1_LD    = 5'd6;
  localparam logic [4:0] S_P1_X     = 5'd7;
  localparam logic [4:0] S_SIFT     = 5'd8;
  localparam logic [4:0] S_SIFT_C1  = 5'd9;
  localparam logic [4:0] S_SIFT_C2  = 5'd10;
  localparam logic [4:0] S_SIFT_CMP = 5'd11;
  localparam logic [4:0] S_SIFT_END = 5'd12;
  localparam logic [4:0] S_P2_A     = 5'd13;
  localparam logic [4:0] S_P2_B     = 5'd14;
  localparam logic [4:0] S_P2_C     = 5'd15;
  localparam logic [4:0] S_FINISH   = 5'd16;

  logic [4:0]    state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] u_r, u_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic [IW-1:0] c_r, c_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          hit_r, hit_nxt;
  logic          phase2_r, phase2_nxt;
  entry_t        x_r, x_nxt;
  entry_t        cv_r, cv_nxt;
  entry_t        best_r, best_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  entry_t        oent_r, oent_nxt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [EW-1:0] rdata_raw;
  logic [IW:0]   c2;

  pqss_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = rdata_raw;
  assign c2    = {u_r, 1'b0};

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    u_nxt       = u_r;
    last_nxt    = last_r;
    c_nxt       = c_r;
    hit_idx_nxt = hit_idx_r;
    hit_nxt     = hit_r;
    phase2_nxt  = phase2_r;
    x_nxt       = x_r;
    cv_nxt      = cv_r;
    best_nxt    = best_r;
    ov_nxt      = ov_r;
    ost_nxt     = ost_r;
    oent_nxt    = oent_r;
    cmd_pop     = 1'b0;
    we          = 1'b0;
    waddr       = u_r;
    wdata       = x_r;
    raddr       = idx_r;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !ov_r) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd;
          oent_nxt = '0;
          ost_nxt  = ST_OK;
          idx_nxt  = IW'(1);
          unique case (cmd.op)
            ACT_INSERT: begin
              ov_nxt = 1'b1;
              if (count_r == IW'(CAPACITY)) begin
                ost_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = count_r + IW'(1);
                wdata     = cmd.ent;
                count_nxt = count_r + IW'(1);
              end
            end
            ACT_REMOVE, ACT_DEQUEUE: begin
              if (count_r == '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = (cmd.op == ACT_REMOVE) ? ST_NOT_FOUND : ST_EMPTY;
              end else begin
                hit_nxt   = 1'b0;
                state_nxt = S_SCAN_RD;
              end
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_SCAN_RD: begin
        raddr     = idx_r;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (cmd_r.op == ACT_REMOVE) begin
          if (rdata == cmd_r.ent) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
            state_nxt   = S_MOVE_RD;
          end else if (idx_r == count_r) begin
            state_nxt = S_SORT;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_SCAN_RD;
          end
        end else begin
          if (idx_r == IW'(1) || rdata.prio > best_r.prio) begin
            best_nxt    = rdata;
            hit_idx_nxt = idx_r;
          end
          if (idx_r == count_r) begin
            hit_nxt   = 1'b1;
            state_nxt = S_MOVE_RD;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_MOVE_RD: begin
        raddr     = count_r;
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        we        = 1'b1;
        waddr     = hit_idx_r;
        wdata     = rdata;
        count_nxt = count_r - IW'(1);
        state_nxt = S_SORT;
      end
      S_SORT: begin
        phase2_nxt = 1'b0;
        idx_nxt    = count_r >> 1;
        state_nxt  = (count_r < IW'(2)) ? S_FINISH : S_P1_LD;
      end
      S_P1_LD: begin
        raddr     = idx_r;
        state_nxt = S_P1_X;
      end
      S_P1_X: begin
        x_nxt     = rdata;
        u_nxt     = idx_r;
        last_nxt  = count_r;
        state_nxt = S_SIFT;
      end
      S_SIFT: begin
        if (c2 > {1'b0, last_r}) begin
          we        = 1'b1;
          waddr     = u_r;
          wdata     = x_r;
          state_nxt = S_SIFT_END;
        end else begin
          raddr     = c2[IW-1:0];
          c_nxt     = c2[IW-1:0];
          state_nxt = S_SIFT_C1;
        end
      end
      S_SIFT_C1: begin
        cv_nxt = rdata;
        if (c_r < last_r) begin
          raddr     = c_r + IW'(1);
          state_nxt = S_SIFT_C2;
        end else begin
          state_nxt = S_SIFT_CMP;
        end
      end
      S_SIFT_C2: begin
        if (rdata.prio > cv_r.prio) begin
          cv_nxt = rdata;
          c_nxt  = c_r + IW'(1);
        end
        state_nxt = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        we    = 1'b1;
        waddr = u_r;
        if (x_r.prio < cv_r.prio) begin
          wdata     = cv_r;
          u_nxt     = c_r;
          state_nxt = S_SIFT;
        end else begin
          wdata     = x_r;
          state_nxt = S_SIFT_END;
        end
      end
      S_SIFT_END: begin
        if (!phase2_r) begin
          if (idx_r == IW'(1)) begin
            phase2_nxt = 1'b1;
            idx_nxt    = count_r;
          end else begin
            idx_nxt = idx_r - IW'(1);
          end
          state_nxt = (idx_r == IW'(1)) ? S_P2_A : S_P1_LD;
        end else if (idx_r == IW'(2)) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt   = idx_r - IW'(1);
          state_nxt = S_P2_A;
        end
      end
      S_P2_A: begin
        raddr     = idx_r;
        state_nxt = S_P2_B;
      end
      S_P2_B: begin
        x_nxt     = rdata;
        raddr     = IW'(1);
        state_nxt = S_P2_C;
      end
      S_P2_C: begin
        we        = 1'b1;
        waddr     = idx_r;
        wdata     = rdata;
        u_nxt     = IW'(1);
        last_nxt  = idx_r - IW'(1);
        state_nxt = S_SIFT;
      end
      S_FINISH: begin
        ov_nxt = 1'b1;
        if (cmd_r.op == ACT_DEQUEUE) begin
          ost_nxt  = ST_OK;
          oent_nxt = best_r;
        end else begin
          ost_nxt = hit_r ? ST_OK : ST_NOT_FOUND;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    u_r       <= u_nxt;
    last_r    <= last_nxt;
    c_r       <= c_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_r     <= hit_nxt;
    phase2_r  <= phase2_nxt;
    x_r       <= x_nxt;
    cv_r      <= cv_nxt;
    best_r    <= best_nxt;
    ost_r     <= ost_nxt;
    oent_r    <= oent_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_value     = oent_r.value;
  assign out_priority  = oent_r.prio;
  assign out_occupancy = OCC_W'(count_r);

  `PQSS_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= IW'(CAPACITY))
  `PQSS_ASSERT_IMPL(a_pop_idle, cmd_pop, state_r == S_IDLE && !ov_r)
  `PQSS_ASSERT_IMPL(a_busy_no_result, state_r != S_IDLE, !ov_r)
  `PQSS_ASSERT_NEXT(a_finish_result, state_r == S_FINISH, ov_r && state_r == S_IDLE)

endmodule

[hdl/priority_queue_sorted_store_unit.sv]
// Insert and unused codes answer in the cycle after the command leaves the queue.
// Remove and dequeue scan the store entry by entry, then heap sort the entries.
// One command is worked at a time; the next is taken only once the result is accepted.
// Reset empties the store and the command queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Priority queue sorted store - top level
// Command queue front end feeding the RAM-based execution back end.
// ----------------------------------------------------------------------------
module priority_queue_sorted_store_unit #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_priority,
  output logic [6:0]         out_occupancy
);
  import pqss_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  pqss_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  pqss_back #(.CAPACITY(CAPACITY)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value     (out_value),
    .out_priority  (out_priority),
    .out_occupancy (out_occupancy)
  );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Priority queue sorted store - testbench
// Sends insert, remove, dequeue and unused commands, with and without random idling on
// both channels. A scoreboard keeps its own copy of the store, repeats the heap sort after
// each remove or dequeue on a non-empty store, and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb;
  import pqss_pkg::*;

  localparam int CAP       = 64;
  localparam int MAX_CYCLE = 4000000;

  class store_scoreboard;
    typedef struct {
      logic [1:0]         status;
      logic signed [31:0] value;
      logic signed [31:0] prio;
      logic [6:0]         occ;
    } result_t;

    result_t            awaited[$];
    logic signed [31:0] slot_val[CAP+1];
    logic signed [31:0] slot_pri[CAP+1];
    int                 count;
    int                 mismatches;
    int                 checked;

    function new();
      count = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic signed [31:0] tv, tp;
      tv = slot_val[a];
      tp = slot_pri[a];
      slot_val[a] = slot_val[b];
      slot_pri[a] = slot_pri[b];
      slot_val[b] = tv;
      slot_pri[b] = tp;
    endfunction

    function void sift_down(int root, int last);
      int u, c;
      u = root;
      while (2 * u <= last) begin
        c = 2 * u;
        if (c < last && slot_pri[c+1] > slot_pri[c]) c = c + 1;
        if (slot_pri[u] < slot_pri[c]) begin
          swap_slots(u, c);
          u = c;
        end else begin
          break;
        end
      end
    endfunction

    function void heap_sort(int n);
      int i;
      for (i = n / 2; i >= 1; i--) sift_down(i, n);
      for (i = n; i >= 2; i--) begin
        swap_slots(1, i);
        sift_down(1, i - 1);
      end
    endfunction

    function bit take_out(logic signed [31:0] v, logic signed [31:0] p);
      int i;
      int hit;
      hit = 0;
      for (i = 1; i <= count; i++) begin
        if (slot_val[i] == v && slot_pri[i] == p) begin
          hit = i;
          break;
        end
      end
      if (hit != 0) begin
        slot_val[hit] = slot_val[count];
        slot_pri[hit] = slot_pri[count];
        count--;
      end
      heap_sort(count);
      return hit != 0;
    endfunction

    function void note_command(logic [1:0] act, logic signed [31:0] v,
                               logic signed [31:0] p);
      result_t r;
      int best, i;
      r.status = ST_OK;
      r.value = '0;
      r.prio = '0;
      case (act)
        ACT_INSERT: begin
          if (count >= CAP) begin
            r.status = ST_FULL;
          end else begin
            count++;
            slot_val[count] = v;
            slot_pri[count] = p;
          end
        end
        ACT_REMOVE: begin
          if (count == 0 || !take_out(v, p)) r.status = ST_NOT_FOUND;
        end
        ACT_DEQUEUE: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            best = 1;
            for (i = 2; i <= count; i++)
              if (slot_pri[i] > slot_pri[best]) best = i;
            r.value = slot_val[best];
            r.prio = slot_pri[best];
            void'(take_out(r.value, r.prio));
          end
        end
        default: ;
      endcase
      r.occ = count[6:0];
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [31:0] v,
                               logic signed [31:0] p, logic [6:0] occ);
      result_t r;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result transfer with nothing awaited");
        return;
      end
      r = awaited.pop_front();
      if (st !== r.status || v !== r.value || p !== r.prio || occ !== r.occ) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch at result %0d: expected st=%0d val=%0d pri=%0d occ=%0d, got st=%0d val=%0d pri=%0d occ=%0d",
                   checked, r.status, r.value, r.prio, r.occ, st, v, p, occ);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic signed [31:0] in_item_value;
  logic signed [31:0] in_item_priority;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic signed [31:0] out_value;
  logic signed [31:0] out_priority;
  logic [6:0]         out_occupancy;

  store_scoreboard sb;
  int              send_idle_pct;
  int              stall_pct;
  int              cycle_count;
  int              sent;

  priority_queue_sorted_store_unit #(.CAPACITY(CAP)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_occupancy    (out_occupancy)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_value, out_priority, out_occupancy);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic signed [31:0] v, logic signed [31:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_item_value    <= v;
    in_item_priority <= p;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_command(act, v, p);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $signed($urandom_range(7)) - 3;
    endcase
  endfunction

  task automatic random_items(int n);
    int k, r, idx;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send(ACT_NONE, $urandom, $urandom);
      end else if (r < 45 && sb.count < 20) begin
        send(ACT_INSERT, pick_word(), pick_word());
      end else if (r < 70) begin
        if (sb.count > 0 && $urandom_range(9) < 7) begin
          idx = $urandom_range(sb.count, 1);
          send(ACT_REMOVE, sb.slot_val[idx], sb.slot_pri[idx]);
        end else begin
          send(ACT_REMOVE, pick_word(), pick_word());
        end
      end else begin
        send(ACT_DEQUEUE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int k;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_INSERT;
    in_item_value = '0;
    in_item_priority = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    cycle_count = 0;
    sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(ACT_DEQUEUE, 0, 0);
    send(ACT_REMOVE, 5, 5);
    send(ACT_NONE, 32'sh7fff_ffff, 32'sh8000_0000);
    send(ACT_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
    send(ACT_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
    send(ACT_INSERT, -1, -1);
    send(ACT_INSERT, 0, 0);
    send(ACT_INSERT, 7, 32'sh7fff_ffff);
    send(ACT_INSERT, 9, 0);
    send(ACT_NONE, 1, 1);
    send(ACT_REMOVE, 9, 1);
    send(ACT_REMOVE, -1, -1);
    send(ACT_DEQUEUE, 0, 0);
    send(ACT_DEQUEUE, 0, 0);
    send(ACT_REMOVE, 0, 0);
    send(ACT_DEQUEUE, 0, 0);
    send(ACT_DEQUEUE, 0, 0);
    send(ACT_DEQUEUE, 0, 0);
    send(ACT_REMOVE, 1, 1);
    drain();

    send_idle_pct = 18;
    stall_pct = 70;
    for (k = 0; k < CAP + 3; k++) send(ACT_INSERT, $urandom, pick_word());
    send(ACT_REMOVE, sb.slot_val[CAP], sb.slot_pri[CAP]);
    send(ACT_INSERT, pick_word(), pick_word());
    send(ACT_REMOVE, 32'sh1234_5678, 32'sh0);
    for (k = 0; k < CAP + 1; k++) send(ACT_DEQUEUE, $urandom, $urandom);
    random_items(150);
    drain();

    send_idle_pct = 70;
    stall_pct = 18;
    random_items(150);
    drain();

    send_idle_pct = 0;
    stall_pct = 0;
    random_items(150);
    drain();
    repeat (100) @(negedge clk);

    $display("Sent %0d commands over three idling phases, including a full fill and drain;",
             sent);
    $display("%0d results checked, %0d mismatches, %0d results still awaited.",
             sb.checked, sb.mismatches, sb.awaited.size());
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
